FILE: hdl/sexpr_pkg.sv
// Shared types and constants for the S-expression tokenizer.
// Holds the lexer state, the result record and the character codes.
// No dependencies; every other file of the block imports this package.
package sexpr_pkg;

   localparam int MAX_RESULTS = 2;
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] SYM_LEN_MAX = 2'd2;

   localparam logic [2:0] KIND_SYMBOL = 3'd0;
   localparam logic [2:0] KIND_STRING = 3'd1;
   localparam logic [2:0] KIND_OPEN   = 3'd2;
   localparam logic [2:0] KIND_CLOSE  = 3'd3;
   localparam logic [2:0] KIND_EOI    = 3'd4;

   localparam logic EVENT_BYTE = 1'b0;
   localparam logic EVENT_END  = 1'b1;

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef enum logic [4:0] {
      MODE_NORMAL     = 5'b00001,
      MODE_STRING     = 5'b00010,
      MODE_ESCAPE     = 5'b00100,
      MODE_COMMENT    = 5'b01000,
      MODE_COMMENT_NL = 5'b10000
   } lex_mode_type;

   typedef struct packed {
      lex_mode_type mode;
      logic [1:0]   sym_len;
      logic         first_hash;
      logic         first_minus;
      logic         dot_seen;
      logic         not_numeric;
   } lex_state_type;

   typedef struct packed {
      logic       event_res;
      logic [2:0] token_kind;
      logic       is_numeric;
      logic [7:0] out_byte;
      logic       last;
   } result_type;

   localparam lex_state_type LEX_RESET = '{
      mode: MODE_NORMAL, sym_len: 2'd0, first_hash: 1'b0,
      first_minus: 1'b0, dot_seen: 1'b0, not_numeric: 1'b0
   };

endpackage

FILE: hdl/sexpr_step.sv
// Combinational lexer step: next state and up to two results for one item.
// Depends on sexpr_pkg for the state, result record and character codes.
module sexpr_step (
   input  sexpr_pkg::lex_state_type cur_state,
   input  logic [7:0]               in_byte,
   input  logic                     at_end,
   output sexpr_pkg::lex_state_type nxt_state,
   output logic [1:0]               res_count,
   output sexpr_pkg::result_type    res_first,
   output sexpr_pkg::result_type    res_second
);
   import sexpr_pkg::*;

   logic          is_sep;
   logic          is_nl;
   logic          is_digit;
   logic          sym_pending;
   logic          sym_num;
   logic          do_classify;
   logic          normal_path;
   logic          pre_en;
   logic          main_en;
   result_type    pre_res;
   result_type    main_res;
   result_type    sym_end_res;
   lex_state_type st;

   function automatic result_type end_res(logic [2:0] kind);
      result_type r;
      r            = '0;
      r.event_res  = EVENT_END;
      r.token_kind = kind;
      return r;
   endfunction

   function automatic result_type byte_res(logic [7:0] c);
      result_type r;
      r           = '0;
      r.event_res = EVENT_BYTE;
      r.out_byte  = c;
      return r;
   endfunction

   function automatic lex_state_type clear_symbol(lex_state_type s);
      lex_state_type r;
      r             = s;
      r.sym_len     = 2'd0;
      r.first_hash  = 1'b0;
      r.first_minus = 1'b0;
      r.dot_seen    = 1'b0;
      r.not_numeric = 1'b0;
      return r;
   endfunction

   assign is_sep      = in_byte inside {CH_LF, CH_CR, CH_SPACE, CH_TAB};
   assign is_nl       = in_byte inside {CH_LF, CH_CR};
   assign is_digit    = in_byte inside {[CH_ZERO:CH_NINE]};
   assign sym_pending = (cur_state.sym_len != 2'd0);
   assign do_classify = sym_pending || ((in_byte != CH_HASH) && (in_byte != CH_MINUS));

   always_comb begin
      if (cur_state.first_hash) begin
         sym_num = (cur_state.sym_len == SYM_LEN_MAX);
      end else if (cur_state.first_minus) begin
         sym_num = (cur_state.sym_len == SYM_LEN_MAX) && !cur_state.not_numeric;
      end else begin
         sym_num = !cur_state.not_numeric;
      end
      sym_end_res            = end_res(KIND_SYMBOL);
      sym_end_res.is_numeric = sym_num;
   end

   always_comb begin
      st          = cur_state;
      pre_en      = 1'b0;
      main_en     = 1'b0;
      pre_res     = '0;
      main_res    = '0;
      normal_path = 1'b0;
      if (at_end) begin
         if (cur_state.mode == MODE_STRING || cur_state.mode == MODE_ESCAPE) begin
            pre_en  = 1'b1;
            pre_res = end_res(KIND_STRING);
         end else if (sym_pending) begin
            pre_en  = 1'b1;
            pre_res = sym_end_res;
         end
         main_en  = 1'b1;
         main_res = end_res(KIND_EOI);
         st       = LEX_RESET;
      end else begin
         case (cur_state.mode)
            MODE_STRING: begin
               if (in_byte == CH_QUOTE) begin
                  main_en  = 1'b1;
                  main_res = end_res(KIND_STRING);
                  st.mode  = MODE_NORMAL;
               end else if (in_byte == CH_BSLASH) begin
                  st.mode = MODE_ESCAPE;
               end else begin
                  main_en  = 1'b1;
                  main_res = byte_res(in_byte);
               end
            end
            MODE_ESCAPE: begin
               main_en  = 1'b1;
               main_res = byte_res(in_byte);
               st.mode  = MODE_STRING;
            end
            MODE_COMMENT: begin
               if (is_nl) begin
                  st.mode = MODE_COMMENT_NL;
               end
            end
            MODE_COMMENT_NL: begin
               normal_path = !is_nl;
            end
            default: begin
               normal_path = 1'b1;
            end
         endcase

         if (normal_path) begin
            st.mode = MODE_NORMAL;
            if (is_sep) begin
               if (sym_pending) begin
                  pre_en  = 1'b1;
                  pre_res = sym_end_res;
                  st      = clear_symbol(st);
               end
            end else if (in_byte == CH_OPEN || in_byte == CH_CLOSE) begin
               if (sym_pending) begin
                  pre_en  = 1'b1;
                  pre_res = sym_end_res;
                  st      = clear_symbol(st);
               end
               main_en  = 1'b1;
               main_res = end_res((in_byte == CH_OPEN) ? KIND_OPEN : KIND_CLOSE);
            end else if (in_byte == CH_SEMI) begin
               st.mode = MODE_COMMENT;
            end else if (in_byte == CH_QUOTE) begin
               if (sym_pending) begin
                  pre_en  = 1'b1;
                  pre_res = sym_end_res;
                  st      = clear_symbol(st);
               end
               st.mode = MODE_STRING;
            end else begin
               if (!sym_pending) begin
                  st.first_hash  = (in_byte == CH_HASH);
                  st.first_minus = (in_byte == CH_MINUS);
               end
               if (do_classify && !is_digit) begin
                  if (in_byte == CH_DOT && !cur_state.dot_seen) begin
                     st.dot_seen = 1'b1;
                  end else begin
                     st.not_numeric = 1'b1;
                  end
               end
               if (cur_state.sym_len != SYM_LEN_MAX) begin
                  st.sym_len = cur_state.sym_len + 2'd1;
               end
               main_en  = 1'b1;
               main_res = byte_res(in_byte);
            end
         end
      end
   end

   always_comb begin
      nxt_state  = st;
      res_count  = {1'b0, pre_en} + {1'b0, main_en};
      res_first  = '0;
      res_second = '0;
      if (pre_en && main_en) begin
         res_first       = pre_res;
         res_second      = main_res;
         res_second.last = 1'b1;
      end else if (pre_en) begin
         res_first      = pre_res;
         res_first.last = 1'b1;
      end else if (main_en) begin
         res_first      = main_res;
         res_first.last = 1'b1;
      end
   end

endmodule

FILE: hdl/sexpr_outq.sv
// Result queue: takes up to two results per cycle, hands out one per cycle on each pop.
// Depends on sexpr_pkg for the result record and the queue sizing constants.
module sexpr_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  sexpr_pkg::result_type push_first,
   input  sexpr_pkg::result_type push_second,
   input  logic                  pop,
   output logic                  has_room,
   output logic                  head_valid,
   output sexpr_pkg::result_type head_res
);
   import sexpr_pkg::*;

   result_type         q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] head_ff;
   logic [Q_PTR_W-1:0] head_in;
   logic [Q_CNT_W-1:0] count_ff;
   logic [Q_CNT_W-1:0] count_in;
   logic [Q_PTR_W-1:0] tail;
   logic [Q_PTR_W-1:0] tail_next;

   assign tail       = head_ff + count_ff[Q_PTR_W-1:0];
   assign tail_next  = tail + Q_PTR_W'(1);
   assign has_room   = (count_ff <= Q_CNT_W'(Q_DEPTH - MAX_RESULTS));
   assign head_valid = (count_ff != '0);
   assign head_res   = q_ff[head_ff];
   assign head_in    = pop ? head_ff + Q_PTR_W'(1) : head_ff;
   assign count_in   = count_ff + Q_CNT_W'(push_count) - Q_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         q_ff[tail] <= push_first;
      end
      if (push_count == 2'd2) begin
         q_ff[tail_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/sexpr_tokenizer.sv
// Top level of the streaming S-expression tokenizer.
// Depends on sexpr_pkg, sexpr_step (lexer logic) and sexpr_outq (result queue).
//
// The req channel carries one source byte per transfer, or an end-of-input
// mark when req_at_end is high. The rsp channel carries token events: a
// content byte (rsp_event_res low) or a token end with its kind, and for a
// symbol whether it reads as a number. rsp_last marks the final result that
// one request caused; a request may cause zero, one or two results.
// The lexer state updates in the cycle of the request transfer and the
// results are registered in a four-entry queue before they show on rsp.
// A request is taken every cycle while the queue holds at most two results;
// a request that causes two results leaves on rsp one result at a time, so
// sustained throughput is one byte per cycle for input that yields at most
// one result per byte. When the receiver stalls the queue fills and
// req_ready drops until room for two results returns.
// Reset empties the queue and puts the lexer in its normal mode with no
// symbol pending; an end-of-input transfer returns it to that same state.
module sexpr_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_at_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_event_res,
   output logic [2:0] rsp_token_kind,
   output logic       rsp_is_numeric,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);
   import sexpr_pkg::*;

   lex_state_type state_ff;
   lex_state_type state_in;
   lex_state_type step_state;
   logic [1:0]    step_count;
   result_type    step_first;
   result_type    step_second;
   result_type    head_res;
   logic          req_xfer;
   logic          has_room;

   assign req_ready = has_room;
   assign req_xfer  = req_valid && has_room;
   assign state_in  = req_xfer ? step_state : state_ff;

   sexpr_step u_step (
      .cur_state  (state_ff),
      .in_byte    (req_in_byte),
      .at_end     (req_at_end),
      .nxt_state  (step_state),
      .res_count  (step_count),
      .res_first  (step_first),
      .res_second (step_second)
   );

   sexpr_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push_count  (req_xfer ? step_count : 2'd0),
      .push_first  (step_first),
      .push_second (step_second),
      .pop         (rsp_valid && rsp_ready),
      .has_room    (has_room),
      .head_valid  (rsp_valid),
      .head_res    (head_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LEX_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_event_res  = head_res.event_res;
   assign rsp_token_kind = head_res.token_kind;
   assign rsp_is_numeric = head_res.is_numeric;
   assign rsp_out_byte   = head_res.out_byte;
   assign rsp_last       = head_res.last;

endmodule

FILE: hdl/sexpr_checker.sv
// Port-level checks for the S-expression tokenizer, bound to its top level.
// Depends on sexpr_pkg for token kinds and event codes.
module sexpr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_event_res,
   input logic [2:0] rsp_token_kind,
   input logic       rsp_is_numeric,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);
   import sexpr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_token_kind) && $stable(rsp_is_numeric)
         && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("rsp transfer changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("queue not empty after reset");

   a_numeric_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_numeric |-> rsp_event_res == EVENT_END
         && rsp_token_kind == KIND_SYMBOL)
      else $error("numeric flag outside a symbol end");

   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EVENT_BYTE |-> rsp_token_kind == KIND_SYMBOL
         && !rsp_is_numeric && rsp_last)
      else $error("content byte with token fields set or not last");

   a_eoi_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EVENT_END && rsp_token_kind == KIND_EOI |-> rsp_last)
      else $error("end of input not the final result");

endmodule

bind sexpr_tokenizer sexpr_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_res  (rsp_event_res),
   .rsp_token_kind (rsp_token_kind),
   .rsp_is_numeric (rsp_is_numeric),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_last       (rsp_last)
);

FILE: sim/sexpr_checker.sv
// Checker for the S-expression tokenizer: watches the req and rsp channels,
// predicts the token events of every req transfer and compares them in order.
// Depends on sexpr_pkg for the result record, lexer state and character codes.
`timescale 1ns / 100ps

module sexpr_tb_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_at_end,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_event_res,
   input  logic [2:0] rsp_token_kind,
   input  logic       rsp_is_numeric,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last,
   output int         error_count,
   output int         expected_count
);
   import sexpr_pkg::*;

   lex_state_type lexer;
   result_type    expected_tokens[$];

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic logic is_newline(input logic [7:0] c);
      return c == CH_LF || c == CH_CR;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string field, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
      end
   endtask

   task automatic push_token(input logic ev, input logic [2:0] kind, input logic num,
                             input logic [7:0] b);
      result_type r;
      r.event_res  = ev;
      r.token_kind = kind;
      r.is_numeric = num;
      r.out_byte   = b;
      r.last       = 1'b0;
      expected_tokens.push_back(r);
   endtask

   task automatic close_symbol();
      logic         num;
      lex_mode_type mode;
      if (lexer.first_hash) begin
         num = lexer.sym_len == SYM_LEN_MAX;
      end else if (lexer.first_minus) begin
         num = lexer.sym_len == SYM_LEN_MAX && !lexer.not_numeric;
      end else begin
         num = !lexer.not_numeric;
      end
      push_token(EVENT_END, KIND_SYMBOL, num, 8'h00);
      mode       = lexer.mode;
      lexer      = LEX_RESET;
      lexer.mode = mode;
   endtask

   task automatic classify_byte(input logic [7:0] c);
      if (c == CH_DOT) begin
         if (lexer.dot_seen) begin
            lexer.not_numeric = 1'b1;
         end else begin
            lexer.dot_seen = 1'b1;
         end
      end else if (c < CH_ZERO || c > CH_NINE) begin
         lexer.not_numeric = 1'b1;
      end
   endtask

   task automatic lex_normal(input logic [7:0] c);
      if (is_space(c)) begin
         if (lexer.sym_len != 2'd0) close_symbol();
      end else if (c == CH_OPEN || c == CH_CLOSE) begin
         if (lexer.sym_len != 2'd0) close_symbol();
         push_token(EVENT_END, c == CH_OPEN ? KIND_OPEN : KIND_CLOSE, 1'b0, 8'h00);
      end else if (c == CH_SEMI) begin
         lexer.mode = MODE_COMMENT;
      end else if (c == CH_QUOTE) begin
         if (lexer.sym_len != 2'd0) close_symbol();
         lexer.mode = MODE_STRING;
      end else begin
         if (lexer.sym_len == 2'd0) begin
            lexer.first_hash  = c == CH_HASH;
            lexer.first_minus = c == CH_MINUS;
            if (!lexer.first_hash && !lexer.first_minus) classify_byte(c);
         end else begin
            classify_byte(c);
         end
         if (lexer.sym_len != SYM_LEN_MAX) lexer.sym_len = lexer.sym_len + 2'd1;
         push_token(EVENT_BYTE, KIND_SYMBOL, 1'b0, c);
      end
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic end_mark);
      int         first_new;
      result_type r;
      first_new = expected_tokens.size();
      if (end_mark) begin
         if (lexer.mode == MODE_STRING || lexer.mode == MODE_ESCAPE) begin
            push_token(EVENT_END, KIND_STRING, 1'b0, 8'h00);
         end else if (lexer.sym_len != 2'd0) begin
            close_symbol();
         end
         push_token(EVENT_END, KIND_EOI, 1'b0, 8'h00);
         lexer = LEX_RESET;
      end else begin
         case (lexer.mode)
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  push_token(EVENT_END, KIND_STRING, 1'b0, 8'h00);
                  lexer.mode = MODE_NORMAL;
               end else if (c == CH_BSLASH) begin
                  lexer.mode = MODE_ESCAPE;
               end else begin
                  push_token(EVENT_BYTE, KIND_SYMBOL, 1'b0, c);
               end
            end
            MODE_ESCAPE: begin
               push_token(EVENT_BYTE, KIND_SYMBOL, 1'b0, c);
               lexer.mode = MODE_STRING;
            end
            MODE_COMMENT: begin
               if (is_newline(c)) lexer.mode = MODE_COMMENT_NL;
            end
            MODE_COMMENT_NL: begin
               if (!is_newline(c)) begin
                  lexer.mode = MODE_NORMAL;
                  lex_normal(c);
               end
            end
            default: begin
               lexer.mode = MODE_NORMAL;
               lex_normal(c);
            end
         endcase
      end
      if (expected_tokens.size() > first_new) begin
         r      = expected_tokens.pop_back();
         r.last = 1'b1;
         expected_tokens.push_back(r);
      end
   endtask

   task automatic check_token();
      result_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch($sformatf("unexpected result: event %0d kind %0d byte %0h",
                                   rsp_event_res, rsp_token_kind, rsp_out_byte));
      end else begin
         want = expected_tokens.pop_front();
         compare_field("event_res", 8'(rsp_event_res), 8'(want.event_res));
         compare_field("token_kind", 8'(rsp_token_kind), 8'(want.token_kind));
         compare_field("is_numeric", 8'(rsp_is_numeric), 8'(want.is_numeric));
         compare_field("out_byte", rsp_out_byte, want.out_byte);
         compare_field("last", 8'(rsp_last), 8'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lexer = LEX_RESET;
         expected_tokens.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_token();
         if (req_valid && req_ready) predict_tokens(req_in_byte, req_at_end);
      end
      expected_count <= expected_tokens.size();
   end

endmodule

FILE: sim/testbench.sv
// Top of the tokenizer testbench: clock, reset, req stimulus and rsp back-pressure.
// Instantiates sexpr_tokenizer and sexpr_tb_checker; depends on sexpr_pkg.
`timescale 1ns / 100ps

module testbench;
   import sexpr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 750;
   localparam int QUIET_FROM     = 650;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_at_end  = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic       rsp_event_res;
   logic [2:0] rsp_token_kind;
   logic       rsp_is_numeric;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   int error_count;
   int expected_count;
   int counted_items = 0;
   bit idling_on     = 1'b1;

   sexpr_tokenizer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_at_end     (req_at_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .rsp_token_kind (rsp_token_kind),
      .rsp_is_numeric (rsp_is_numeric),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last)
   );

   sexpr_tb_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_at_end     (req_at_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .rsp_token_kind (rsp_token_kind),
      .rsp_is_numeric (rsp_is_numeric),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .error_count    (error_count),
      .expected_count (expected_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic is_delimiter(input logic [7:0] c);
      return c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB ||
             c == CH_OPEN || c == CH_CLOSE || c == CH_SEMI || c == CH_QUOTE;
   endfunction

   task automatic send_item(input logic [7:0] b, input logic end_mark, input bit counted);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_at_end  <= end_mark;
      do @(posedge clock); while (!req_ready);
      if (counted) counted_items++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0, 1'b1);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
   endtask

   task automatic send_token();
      int         pick;
      int         len;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
               0:          c = i == 0 ? CH_MINUS : CH_DOT;
               1:          c = i == 0 ? CH_HASH : CH_DOT;
               2, 3, 4, 5: c = CH_ZERO + 8'($urandom_range(0, 9));
               6:          c = "a" + 8'($urandom_range(0, 25));
               7:          c = CH_MINUS;
               default: begin
                  do c = 8'($urandom_range(0, 255)); while (is_delimiter(c));
               end
            endcase
            send_item(c, 1'b0, 1'b1);
         end
      end else if (pick < 50) begin
         send_item(CH_QUOTE, 1'b0, 1'b1);
         len = $urandom_range(0, 6);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               send_item(CH_BSLASH, 1'b0, 1'b1);
               send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end else begin
               do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
               send_item(c, 1'b0, 1'b1);
            end
         end
         if ($urandom_range(0, 9) != 0) send_item(CH_QUOTE, 1'b0, 1'b1);
      end else if (pick < 65) begin
         send_item($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE, 1'b0, 1'b1);
      end else if (pick < 82) begin
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
               0:       c = CH_SPACE;
               1:       c = CH_TAB;
               2:       c = CH_LF;
               default: c = CH_CR;
            endcase
            send_item(c, 1'b0, 1'b1);
         end
      end else if (pick < 88) begin
         send_item(CH_SEMI, 1'b0, 1'b1);
         len = $urandom_range(0, 5);
         for (int i = 0; i < len; i++) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
            send_item(c, 1'b0, 1'b1);
         end
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++) send_item($urandom_range(0, 1) ? CH_LF : CH_CR,
                                                  1'b0, 1'b1);
      end else if (pick < 96) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
   endtask

   initial begin : receiver
      @(posedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_text("(-1.5 # -)");
      send_text("a\"\\\"\"");
      send_text("q;\n\rr");
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_text("\"\\");
      send_item(8'hFF, 1'b1, 1'b1);
      send_text(" ");
      send_item(8'h00, 1'b1, 1'b1);
      wait_for_results();
      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         if (counted_items >= QUIET_FROM) idling_on = 1'b0;
         send_token();
      end
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
